FILE: hdl/fmdm_pkg.sv
// Shared types, constants and helper functions of the frame difference motion mask.
// Used by every module of the block; depends on nothing else.
package fmdm_pkg;

	localparam int MAX_WIDTH = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int PIX_W = 8;
	localparam int DIM_W = 7;
	localparam int CFG_IDX_W = 2;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int OUT_DEPTH = 4;
	localparam int OPTR_W = $clog2(OUT_DEPTH);
	localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

	localparam logic [PIX_W-1:0] DEFAULT_THRESHOLD = 8'd16;
	localparam logic [DIM_W-1:0] DEFAULT_WIDTH = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] DEFAULT_HEIGHT = DIM_W'(MAX_HEIGHT);

	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_READ = 1'b1;

	typedef struct packed {
		logic is_read;
		logic [PIX_W-1:0] pix;
		logic [ADDR_W-1:0] addr;
		logic last;
		logic have_ref;
	} cmd_t;

	typedef struct packed {
		logic mask_bit;
		logic frame_done;
		logic frame_motion;
		logic [PIX_W-1:0] frame_max_diff;
	} res_t;

	typedef struct packed {
		logic valid;
		logic full;
		logic [QCNT_W-1:0] count;
	} qstat_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] limit);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > limit) begin
			r = limit;
		end
		return r;
	endfunction

endpackage

FILE: hdl/fmdm_front.sv
// Front end: accepts requests, tracks the raster position and frame state,
// and turns each request into a command for the queue. Depends on fmdm_pkg.
module fmdm_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         req_type,
	input  logic [fmdm_pkg::PIX_W-1:0]   pixel_value,
	input  logic [fmdm_pkg::ADDR_W-1:0]  read_index,
	input  logic [fmdm_pkg::DIM_W-1:0]   frame_width,
	input  logic [fmdm_pkg::DIM_W-1:0]   frame_height,
	input  logic                         q_full,
	input  logic                         clearing,
	output logic                         push,
	output fmdm_pkg::cmd_t               cmd
);
	import fmdm_pkg::*;

	logic [ADDR_W-1:0] pos_q;
	logic have_ref_q;
	logic [DIM_W-1:0] w;
	logic [DIM_W-1:0] h;
	logic [2*DIM_W-1:0] area;
	logic [2*DIM_W-1:0] area_m1;
	logic [ADDR_W-1:0] last_pos;
	logic frame_end;
	logic is_pixel;

	always_comb begin
		w = clamp_dim(frame_width, DIM_W'(MAX_WIDTH));
		h = clamp_dim(frame_height, DIM_W'(MAX_HEIGHT));
		area = {{DIM_W{1'b0}}, w} * {{DIM_W{1'b0}}, h};
		area_m1 = area - (2*DIM_W)'(1);
		last_pos = area_m1[ADDR_W-1:0];
		frame_end = (pos_q >= last_pos);
		is_pixel = (req_type == REQ_PIXEL);
	end

	assign in_ready = !q_full && !clearing;
	assign push = in_valid && in_ready;

	always_comb begin
		cmd.is_read = !is_pixel;
		cmd.pix = pixel_value;
		cmd.addr = is_pixel ? pos_q : read_index;
		cmd.last = is_pixel && frame_end;
		cmd.have_ref = have_ref_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			have_ref_q <= 1'b0;
		end else if (push && is_pixel) begin
			if (frame_end) begin
				pos_q <= '0;
				have_ref_q <= 1'b1;
			end else begin
				pos_q <= pos_q + ADDR_W'(1);
			end
		end
	end

endmodule

FILE: hdl/fmdm_queue.sv
// Four-entry command queue between the front end and the back end.
// Depends on fmdm_pkg for the command and status types.
module fmdm_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  fmdm_pkg::cmd_t    push_data,
	input  logic              pop,
	output fmdm_pkg::cmd_t    head,
	output fmdm_pkg::qstat_t  stat
);
	import fmdm_pkg::*;

	cmd_t entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign head = entry_q[rd_ptr_q];
	assign stat.valid = (cnt_q != '0);
	assign stat.full = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.count = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

FILE: hdl/fmdm_back.sv
// Back end: holds the reference frame and mask stores, forms differences,
// tracks the frame maximum and buffers results. Depends on fmdm_pkg.
module fmdm_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [fmdm_pkg::PIX_W-1:0]  threshold,
	input  logic                        q_valid,
	input  fmdm_pkg::cmd_t              q_head,
	output logic                        q_pop,
	output logic                        clearing,
	output logic                        out_valid,
	input  logic                        out_ready,
	output fmdm_pkg::res_t              res
);
	import fmdm_pkg::*;

	logic [PIX_W-1:0] prev_mem [STORE_DEPTH];
	logic mask_mem [STORE_DEPTH];
	logic [PIX_W-1:0] prev_rd_q;
	logic mask_rd_q;

	logic clr_q;
	logic [ADDR_W-1:0] clr_addr_q;

	logic valid_s1;
	cmd_t cmd_s1;
	logic hit_prev_s1;
	logic hit_mask_s1;
	logic [PIX_W-1:0] fwd_pix_s1;
	logic fwd_bit_s1;

	logic [PIX_W-1:0] run_max_q;
	logic suppress_q;

	res_t out_q [OUT_DEPTH];
	logic [OPTR_W-1:0] out_wr_q;
	logic [OPTR_W-1:0] out_rd_q;
	logic [OCNT_W-1:0] out_cnt_q;

	logic [OCNT_W:0] inflight;
	logic out_pop;
	logic [PIX_W-1:0] ref_pix;
	logic cur_mask;
	logic [PIX_W-1:0] diff;
	logic px_bit;
	logic [PIX_W-1:0] new_max;
	logic motion;
	logic px_write;
	logic mask_we;
	logic [ADDR_W-1:0] mask_waddr;
	logic mask_wdata;
	logic same_addr;
	res_t res_s1;

	assign clearing = clr_q;
	assign inflight = {1'b0, out_cnt_q} + {{OCNT_W{1'b0}}, valid_s1};
	assign q_pop = q_valid && !clr_q && (inflight < (OCNT_W+1)'(OUT_DEPTH));
	assign out_valid = (out_cnt_q != '0);
	assign out_pop = out_valid && out_ready;
	assign res = out_q[out_rd_q];

	always_comb begin
		ref_pix = hit_prev_s1 ? fwd_pix_s1 : prev_rd_q;
		cur_mask = hit_mask_s1 ? fwd_bit_s1 : mask_rd_q;
		diff = (cmd_s1.pix >= ref_pix) ? (cmd_s1.pix - ref_pix) : (ref_pix - cmd_s1.pix);
		px_bit = cmd_s1.have_ref && (diff >= threshold);
		new_max = (cmd_s1.have_ref && (diff > run_max_q)) ? diff : run_max_q;
		motion = ({1'b0, new_max} >= {threshold, 1'b0});
		px_write = valid_s1 && !cmd_s1.is_read;
		if (cmd_s1.is_read) begin
			res_s1.mask_bit = cur_mask && !suppress_q;
			res_s1.frame_done = 1'b0;
			res_s1.frame_motion = 1'b0;
			res_s1.frame_max_diff = run_max_q;
		end else begin
			res_s1.mask_bit = px_bit;
			res_s1.frame_done = cmd_s1.last;
			res_s1.frame_motion = cmd_s1.last && motion;
			res_s1.frame_max_diff = new_max;
		end
		if (clr_q) begin
			mask_we = 1'b1;
			mask_waddr = clr_addr_q;
			mask_wdata = 1'b0;
		end else begin
			mask_we = px_write && cmd_s1.have_ref;
			mask_waddr = cmd_s1.addr;
			mask_wdata = px_bit;
		end
		same_addr = px_write && (cmd_s1.addr == q_head.addr);
	end

	always_ff @(posedge clk) begin
		if (px_write) begin
			prev_mem[cmd_s1.addr] <= cmd_s1.pix;
		end
		prev_rd_q <= prev_mem[q_head.addr];
	end

	always_ff @(posedge clk) begin
		if (mask_we) begin
			mask_mem[mask_waddr] <= mask_wdata;
		end
		mask_rd_q <= mask_mem[q_head.addr];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_s1 <= q_head;
			hit_prev_s1 <= same_addr && !q_head.is_read;
			hit_mask_s1 <= same_addr && q_head.is_read && cmd_s1.have_ref;
			fwd_pix_s1 <= cmd_s1.pix;
			fwd_bit_s1 <= px_bit;
		end
		if (valid_s1) begin
			out_q[out_wr_q] <= res_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
			if (clr_addr_q == ADDR_W'(STORE_DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			run_max_q <= '0;
			suppress_q <= 1'b1;
		end else begin
			valid_s1 <= q_pop;
			if (px_write) begin
				if (cmd_s1.last) begin
					run_max_q <= '0;
					suppress_q <= !motion;
				end else begin
					run_max_q <= new_max;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_q <= '0;
			out_rd_q <= '0;
			out_cnt_q <= '0;
		end else begin
			if (valid_s1) begin
				out_wr_q <= out_wr_q + OPTR_W'(1);
			end
			if (out_pop) begin
				out_rd_q <= out_rd_q + OPTR_W'(1);
			end
			if (valid_s1 && !out_pop) begin
				out_cnt_q <= out_cnt_q + OCNT_W'(1);
			end else if (out_pop && !valid_s1) begin
				out_cnt_q <= out_cnt_q - OCNT_W'(1);
			end
		end
	end

endmodule

FILE: hdl/frame_difference_motion_mask.sv
// Top level of the frame difference motion mask: configuration registers and
// the front end, command queue and back end. Depends on fmdm_pkg and the fmdm modules.
//
// Requests enter on in_valid/in_ready: a pixel request carries the next pixel in
// raster order, a read request asks for one mask bit at read_index. Every request
// gives exactly one result on out_valid/out_ready, in request order.
// Configuration writes (threshold, frame width, frame height) use cfg_valid and
// cfg_ready with cfg_index and cfg_data; cfg_ready is always high. The user must make
// writes only while no request is outstanding; the block does not enforce this.
// A request accepted into an empty block passes the command queue, the stage register
// and the output buffer; the block takes one request per clock when the receiver
// keeps up. The rate is set by the reference and mask stores, each with one read and
// one write port. After reset the mask store is cleared one entry per cycle; in_ready
// stays low until it finishes. The first frame only loads the reference frame.
// When the receiver stalls, up to four results wait in the output buffer and up
// to four requests in the command queue; in_ready then drops until space frees.
module frame_difference_motion_mask (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         req_type,
	input  logic [fmdm_pkg::PIX_W-1:0]   pixel_value,
	input  logic [fmdm_pkg::ADDR_W-1:0]  read_index,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         mask_bit,
	output logic                         frame_done,
	output logic                         frame_motion,
	output logic [fmdm_pkg::PIX_W-1:0]   frame_max_diff,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [fmdm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fmdm_pkg::PIX_W-1:0]   cfg_data
);
	import fmdm_pkg::*;

	logic [PIX_W-1:0] threshold_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;

	logic push;
	cmd_t push_cmd;
	logic q_pop;
	cmd_t q_head;
	qstat_t q_stat;
	logic clearing;
	res_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= DEFAULT_THRESHOLD;
			width_q <= DEFAULT_WIDTH;
			height_q <= DEFAULT_HEIGHT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_THRESHOLD: begin
					threshold_q <= cfg_data;
				end
				CFG_FRAME_WIDTH: begin
					width_q <= cfg_data[DIM_W-1:0];
				end
				CFG_FRAME_HEIGHT: begin
					height_q <= cfg_data[DIM_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	fmdm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.pixel_value  (pixel_value),
		.read_index   (read_index),
		.frame_width  (width_q),
		.frame_height (height_q),
		.q_full       (q_stat.full),
		.clearing     (clearing),
		.push         (push),
		.cmd          (push_cmd)
	);

	fmdm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_cmd),
		.pop       (q_pop),
		.head      (q_head),
		.stat      (q_stat)
	);

	fmdm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.threshold (threshold_q),
		.q_valid   (q_stat.valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.clearing  (clearing),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign mask_bit = res.mask_bit;
	assign frame_done = res.frame_done;
	assign frame_motion = res.frame_motion;
	assign frame_max_diff = res.frame_max_diff;

`ifndef NO_ASSERTIONS
	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !in_ready)
		else $error("Request accepted while the mask store is being cleared.");

	a_queue_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= QCNT_W'(QUEUE_DEPTH))
		else $error("Command queue holds more entries than its depth.");

	a_accept_reaches_queue: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (q_stat.count != '0))
		else $error("Accepted request did not enter the command queue.");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_stat.valid)
		else $error("Back end popped an empty command queue.");
`endif

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for frame_difference_motion_mask: directed and random pixel and
// read requests, each result checked against an in-bench model of the frame and mask stores.
// Depends on fmdm_pkg and the RTL of the block only.
module testbench;
	import fmdm_pkg::*;

	localparam int CLK_HALF = 4;
	localparam int CYCLE_LIMIT = 250000;
	localparam int RANDOM_ITEMS = 1600;
	localparam int SETTLE_CYCLES = 8;
	localparam int MOTION_FACTOR = 2;
	localparam int REF_LINES = 8;
	localparam int REF_WIDTH = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct packed {
		logic kind;
		logic [PIX_W-1:0] luma;
		logic [ADDR_W-1:0] index;
	} request_t;

	typedef enum logic [1:0] {RX_STEADY, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_t;
	typedef enum logic [1:0] {SCENE_STILL, SCENE_NOISY, SCENE_PATCH} scene_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic req_type = REQ_PIXEL;
	logic [PIX_W-1:0] pixel_value = '0;
	logic [ADDR_W-1:0] read_index = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic mask_bit;
	logic frame_done;
	logic frame_motion;
	logic [PIX_W-1:0] frame_max_diff;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [PIX_W-1:0] cfg_data = '0;

	frame_difference_motion_mask i_dut (.*);

	logic [PIX_W-1:0] ref_luma [STORE_DEPTH];
	logic mask_store [STORE_DEPTH];
	logic [PIX_W-1:0] thr_reg = DEFAULT_THRESHOLD;
	logic [DIM_W-1:0] width_reg = DEFAULT_WIDTH;
	logic [DIM_W-1:0] height_reg = DEFAULT_HEIGHT;
	int unsigned next_pos = 0;
	int unsigned peak_diff = 0;
	int unsigned loaded_span = 0;
	logic ref_loaded = 1'b0;
	logic mask_hidden = 1'b1;

	request_t pending_requests[$];
	res_t expected_results[$];
	request_t on_bus;

	int unsigned err_count = 0;
	int unsigned cycle_count = 0;
	int unsigned results_seen = 0;
	int unsigned items_queued = 0;
	int unsigned pixels_sent = 0;
	int unsigned reads_sent = 0;
	int unsigned frames_moving = 0;
	int unsigned frames_still = 0;
	int unsigned reg_writes = 0;

	function automatic int unsigned fit_dim(logic [DIM_W-1:0] v, int unsigned limit);
		if (v == '0) return 1;
		if (v > limit) return limit;
		return v;
	endfunction

	function automatic res_t predict_request(request_t r);
		res_t o;
		int unsigned last_pos;
		int unsigned pos;
		int unsigned diff;
		o = '0;
		if (r.kind == REQ_READ) begin
			reads_sent++;
			o.mask_bit = mask_store[r.index] & ~mask_hidden;
			o.frame_max_diff = PIX_W'(peak_diff);
			return o;
		end
		pixels_sent++;
		last_pos = fit_dim(width_reg, MAX_WIDTH) * fit_dim(height_reg, MAX_HEIGHT) - 1;
		pos = (next_pos >= STORE_DEPTH) ? STORE_DEPTH - 1 : next_pos;
		if (ref_loaded) begin
			diff = (r.luma >= ref_luma[pos]) ? r.luma - ref_luma[pos] : ref_luma[pos] - r.luma;
			o.mask_bit = (diff >= thr_reg);
			mask_store[pos] = o.mask_bit;
			if (diff > peak_diff) peak_diff = diff;
		end
		ref_luma[pos] = r.luma;
		if (pos + 1 > loaded_span) loaded_span = pos + 1;
		o.frame_max_diff = PIX_W'(peak_diff);
		if (pos >= last_pos) begin
			o.frame_done = 1'b1;
			o.frame_motion = (peak_diff >= MOTION_FACTOR * thr_reg);
			mask_hidden = ~o.frame_motion;
			if (o.frame_motion) frames_moving++;
			else frames_still++;
			peak_diff = 0;
			next_pos = 0;
			ref_loaded = 1'b1;
		end else begin
			next_pos = pos + 1;
		end
		return o;
	endfunction

	task automatic flag_mismatch(string what);
		err_count++;
		if (err_count <= 40) $display("t=%0t result %0d: %s", $time, results_seen, what);
	endtask

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d results outstanding.", cycle_count,
				expected_results.size());
			$display("** frame_difference_motion_mask: FAILED **");
			$finish;
		end
	end

	int burst_left = 1;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_results.push_back(predict_request(on_bus));
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					on_bus = pending_requests.pop_front();
					in_valid <= 1'b1;
					req_type <= on_bus.kind;
					pixel_value <= on_bus.luma;
					read_index <= on_bus.index;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	rx_mode_t rx_mode = RX_STEADY;
	int rx_left = 0;
	int hold_left = 0;
	logic held_once = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					flag_mismatch("result arrived with nothing expected");
				end else begin
					want = expected_results.pop_front();
					if (mask_bit !== want.mask_bit)
						flag_mismatch($sformatf("mask_bit %b, expected %b", mask_bit,
							want.mask_bit));
					if (frame_done !== want.frame_done)
						flag_mismatch($sformatf("frame_done %b, expected %b", frame_done,
							want.frame_done));
					if (frame_motion !== want.frame_motion)
						flag_mismatch($sformatf("frame_motion %b, expected %b", frame_motion,
							want.frame_motion));
					if (frame_max_diff !== want.frame_max_diff)
						flag_mismatch($sformatf("frame_max_diff %0d, expected %0d",
							frame_max_diff, want.frame_max_diff));
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!held_once && results_seen >= 400 && pending_requests.size() > 16) begin
				// Long stall so that the output buffer and command queue fill and in_ready drops.
				held_once = 1'b1;
				hold_left = 300;
				out_ready <= 1'b0;
			end else begin
				if (rx_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 3));
					rx_left = $urandom_range(8, 64);
				end else begin
					rx_left--;
				end
				case (rx_mode)
					RX_STEADY: out_ready <= 1'b1;
					RX_HALF: out_ready <= $urandom_range(0, 1);
					RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	function automatic void queue_pixel(logic [PIX_W-1:0] luma);
		pending_requests.push_back('{REQ_PIXEL, luma, ADDR_W'($urandom)});
		items_queued++;
	endfunction

	function automatic void queue_read(logic [ADDR_W-1:0] idx);
		pending_requests.push_back('{REQ_READ, PIX_W'($urandom), idx});
		items_queued++;
	endfunction

	task automatic settle();
		do @(negedge clk);
		while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PIX_W-1:0] data);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		reg_writes++;
		case (idx)
			CFG_THRESHOLD: thr_reg = data;
			CFG_FRAME_WIDTH: width_reg = data[DIM_W-1:0];
			CFG_FRAME_HEIGHT: height_reg = data[DIM_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(logic [PIX_W-1:0] thr, logic [PIX_W-1:0] w, logic [PIX_W-1:0] h);
		int unsigned cw;
		int unsigned ch;
		cw = fit_dim(w[DIM_W-1:0], MAX_WIDTH);
		ch = fit_dim(h[DIM_W-1:0], MAX_HEIGHT);
		if (ref_loaded && cw * ch > loaded_span) begin
			// A frame must never run past the part of the reference store that holds pixels.
			if (cw > loaded_span) w = PIX_W'(loaded_span);
			h = PIX_W'(loaded_span / fit_dim(w[DIM_W-1:0], MAX_WIDTH));
		end
		write_reg(CFG_THRESHOLD, thr);
		write_reg(CFG_FRAME_WIDTH, w);
		write_reg(CFG_FRAME_HEIGHT, h);
	endtask

	task automatic random_phase();
		int unsigned area;
		int unsigned pos;
		int unsigned count;
		int unsigned patch_lo;
		int unsigned patch_hi;
		int unsigned pick;
		scene_t scene;
		logic [PIX_W-1:0] thr;
		logic [PIX_W-1:0] wv;
		logic [PIX_W-1:0] hv;
		logic [PIX_W-1:0] luma;
		case ($urandom_range(0, 5))
			0: begin
				wv = $urandom_range(0, 4);
				hv = $urandom_range(60, 127);
			end
			1: begin
				wv = $urandom_range(60, 127);
				hv = $urandom_range(0, 4);
			end
			4: begin
				wv = $urandom_range(0, 127);
				hv = $urandom_range(0, 127);
			end
			5: begin
				wv = $urandom_range(0, 1);
				hv = $urandom_range(0, 1);
			end
			default: begin
				wv = $urandom_range(1, 8);
				hv = $urandom_range(1, 6);
			end
		endcase
		wv[PIX_W-1] = $urandom_range(0, 1);
		hv[PIX_W-1] = $urandom_range(0, 1);
		pick = $urandom_range(0, 9);
		if (pick == 0) thr = 8'd0;
		else if (pick == 1) thr = 8'd255;
		else if (pick == 2) thr = $urandom_range(0, 255);
		else thr = $urandom_range(4, 48);
		configure(thr, wv, hv);

		area = fit_dim(width_reg, MAX_WIDTH) * fit_dim(height_reg, MAX_HEIGHT);
		pos = next_pos;
		scene = scene_t'($urandom_range(0, 2));
		patch_lo = $urandom_range(0, area - 1);
		patch_hi = $urandom_range(patch_lo, area - 1);
		count = $urandom_range(20, 120);
		repeat (count) begin
			if ($urandom_range(0, 5) == 0) begin
				queue_read($urandom_range(0, 1) ? ADDR_W'($urandom) :
					ADDR_W'($urandom_range(0, area - 1)));
			end else begin
				luma = PIX_W'(pos * 37 + 11) + PIX_W'($urandom_range(0, 2));
				if (scene == SCENE_NOISY) luma = $urandom;
				else if (scene == SCENE_PATCH && pos >= patch_lo && pos <= patch_hi)
					luma = luma + 8'd128;
				queue_pixel(luma);
				pos = (pos >= area - 1) ? 0 : pos + 1;
			end
		end
		settle();
	endtask

	initial begin
		int i;
		foreach (mask_store[i]) mask_store[i] = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reads before any frame has ended see the mask suppressed.
		queue_read('0);
		queue_read('1);
		settle();

		// The first frame only loads the reference; extremes sit at its first positions.
		configure(8'd40, PIX_W'(REF_WIDTH), PIX_W'(REF_LINES));
		for (i = 0; i < REF_WIDTH * REF_LINES; i++) begin
			if (i == 100) queue_read(ADDR_W'(5));
			queue_pixel((i < 4) ? ((i % 2) ? 8'hFF : 8'h00) : PIX_W'($urandom));
		end
		settle();

		// Full-scale differences against the largest threshold: marked, but no frame motion.
		configure(8'd255, 8'd2, 8'd2);
		queue_pixel(8'hFF);
		queue_pixel(8'h00);
		queue_pixel(8'h00);
		queue_read(ADDR_W'(0));
		queue_pixel(8'h80);
		queue_read(ADDR_W'(0));
		queue_read(ADDR_W'(1));
		settle();

		// Zero threshold marks every pixel; a width of zero counts as one.
		configure(8'd0, 8'd0, 8'd4);
		queue_pixel(8'h00);
		queue_pixel(8'hFF);
		queue_pixel(8'h7F);
		queue_pixel(8'hFF);
		queue_read(ADDR_W'(0));
		queue_read(ADDR_W'(1));
		queue_read('1);
		settle();

		// Oversized width saturates; then the frame shrinks mid-frame and ends early.
		configure(8'd1, 8'hFF, 8'h81);
		repeat (6) queue_pixel(PIX_W'($urandom));
		settle();
		write_reg(CFG_FRAME_WIDTH, 8'd4);
		write_reg(CFG_FRAME_HEIGHT, 8'd0);
		queue_pixel(PIX_W'($urandom));
		queue_read(ADDR_W'(3));
		settle();
		write_reg(CFG_SPARE, 8'hA5);

		while (items_queued < RANDOM_ITEMS) random_phase();

		settle();
		repeat (2 * SETTLE_CYCLES) @(negedge clk);
		if (expected_results.size() != 0)
			flag_mismatch($sformatf("%0d expected results never arrived",
				expected_results.size()));
		$display("Checked %0d requests (%0d pixels, %0d reads) over %0d register writes.",
			results_seen, pixels_sent, reads_sent, reg_writes);
		$display("Frame ends with motion: %0d, without: %0d; long output stall %s.",
			frames_moving, frames_still, held_once ? "applied" : "not reached");
		if (err_count == 0) begin
			$display("** frame_difference_motion_mask: PASSED **");
		end else begin
			$display("%0d mismatches found.", err_count);
			$display("** frame_difference_motion_mask: FAILED **");
		end
		$finish;
	end

endmodule
